/* sv/masked_byte_pattern_search_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern search
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MBPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
// next-cycle implication
`define MBPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define MBPS_ASSERT_IMP(label, ante, cons)
`define MBPS_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* sv/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and register map of the masked byte pattern search.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int ADDR_W   = 6;   // eight 64-bit slots
	localparam int DATA_W   = 64;
	localparam int LEN_W    = 6;
	localparam int CARE_W   = 32;
	localparam int REG_BYTES = 32; // pattern bytes held in registers

	// register indexes (paddr[5:3])
	localparam logic [2:0] REG_PAT0 = 3'd0;
	localparam logic [2:0] REG_PAT1 = 3'd1;
	localparam logic [2:0] REG_PAT2 = 3'd2;
	localparam logic [2:0] REG_PAT3 = 3'd3;
	localparam logic [2:0] REG_CARE = 3'd4;
	localparam logic [2:0] REG_LEN  = 3'd5;

	// per-cell compare setting, aligned to the window position
	typedef struct packed {
		logic       care;
		logic [7:0] pat;
	} cell_ctl_t;

endpackage

/* sv/mbps_regs.sv */
// ----------------------------------------------------------------------------
// mbps_regs
// APB register file; aligns pattern and care bits to window positions.
// ----------------------------------------------------------------------------
module mbps_regs #(
	parameter int MAX_PATTERN_BYTES = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [mbps_pkg::ADDR_W-1:0]              paddr,
	input  logic [mbps_pkg::DATA_W-1:0]              pwdata,
	output logic [mbps_pkg::DATA_W-1:0]              prdata,
	output logic                                     pready,
	output logic [mbps_pkg::LEN_W-1:0]               pattern_length,
	output mbps_pkg::cell_ctl_t [MAX_PATTERN_BYTES-1:0] cell_ctl
);

	logic [3:0][63:0]                    pat_word_q;
	logic [mbps_pkg::CARE_W-1:0]         care_q;
	logic [mbps_pkg::LEN_W-1:0]          len_q;
	logic [mbps_pkg::REG_BYTES-1:0][7:0] pat_bytes;
	logic [2:0]                          idx;
	logic                                wr;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_word_q <= '0;
			care_q     <= '0;
			len_q      <= '0;
		end else if (wr) begin
			case (idx)
				mbps_pkg::REG_PAT0: pat_word_q[0] <= pwdata;
				mbps_pkg::REG_PAT1: pat_word_q[1] <= pwdata;
				mbps_pkg::REG_PAT2: pat_word_q[2] <= pwdata;
				mbps_pkg::REG_PAT3: pat_word_q[3] <= pwdata;
				mbps_pkg::REG_CARE: care_q        <= pwdata[mbps_pkg::CARE_W-1:0];
				mbps_pkg::REG_LEN:  len_q         <= pwdata[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mbps_pkg::REG_PAT0: prdata = pat_word_q[0];
			mbps_pkg::REG_PAT1: prdata = pat_word_q[1];
			mbps_pkg::REG_PAT2: prdata = pat_word_q[2];
			mbps_pkg::REG_PAT3: prdata = pat_word_q[3];
			mbps_pkg::REG_CARE: prdata = {{(mbps_pkg::DATA_W-mbps_pkg::CARE_W){1'b0}}, care_q};
			mbps_pkg::REG_LEN:  prdata = {{(mbps_pkg::DATA_W-mbps_pkg::LEN_W){1'b0}}, len_q};
			default:            prdata = '0;
		endcase
	end

	// byte 8w+k of the pattern sits in word w, bits 8k up
	assign pat_bytes      = pat_word_q;
	assign pattern_length = len_q;

	// window entry i meets pattern byte len-1-i
	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_align
		localparam logic [6:0] IDX  = 7'(i);
		localparam logic [6:0] IDX1 = 7'(i + 1);
		logic [6:0] j;
		logic       active;
		assign j      = {1'b0, len_q} - IDX1;
		assign active = IDX < {1'b0, len_q};
		assign cell_ctl[i].care = active && (j[6:5] == 2'b00) && care_q[j[4:0]];
		assign cell_ctl[i].pat  = pat_bytes[j[4:0]];
	end

endmodule

/* sv/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: shifts towards older positions and checks its compare.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic                clk,
	input  logic                shift,
	input  logic [7:0]          din,
	input  mbps_pkg::cell_ctl_t ctl,
	output logic [7:0]          q,
	output logic                ok
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign q  = byte_q;
	assign ok = !ctl.care || (byte_q == ctl.pat);

endmodule

/* sv/masked_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Scans a byte stream for a pattern with wildcard bytes, one byte a cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | tdata[7:0] data_byte, tlast last_byte
//  m_axis   | out | tdata[31:0] match_offset, tuser[0] found
//  apb      | in  | 64-bit registers at 8*i, paddr[5:3] selects
//
//  One byte is taken every cycle unless m_axis stalls. A byte enters the cell
//  chain on accept, is compared in the following cycle (stage s1) against all
//  cells at once, and its result, if any, lands in the output register, which
//  drives m_tvalid, when s1 advances. The window, pattern and found flag sit
//  in flip-flops; there is no clearing pass after reset.
//  A stall on m_axis holds s1 and so drops s_tready within the same cycle.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_search_macros.svh"

module masked_byte_pattern_search #(
	parameter int MAX_PATTERN_BYTES = 32,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] data_byte
	input  logic                          s_tlast,  // last_byte
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,  // [31:0] match_offset
	output logic [0:0]                    m_tuser,  // [0] found
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbps_pkg::ADDR_W-1:0]   paddr,
	input  logic [mbps_pkg::DATA_W-1:0]   pwdata,
	output logic [mbps_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
	localparam logic [6:0]             LEN_MAX = 7'(MAX_PATTERN_BYTES);

	logic [mbps_pkg::LEN_W-1:0]                  len;
	mbps_pkg::cell_ctl_t [MAX_PATTERN_BYTES-1:0] cell_ctl;
	logic [MAX_PATTERN_BYTES-1:0][7:0]           win;
	logic [MAX_PATTERN_BYTES-1:0]                cell_ok;

	logic                   in_acc;
	logic                   adv;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   found_q;
	logic                   valid_s1;
	logic                   last_s1;
	logic [OFFSET_BITS-1:0] pos_s1;

	logic                   out_valid_q;
	logic                   out_found_q;
	logic [31:0]            out_offset_q;

	logic [OFFSET_BITS-1:0] len_m1;
	logic                   len_ok;
	logic                   hit;
	logic                   emit;
	logic [OFFSET_BITS-1:0] offset_full;

	mbps_regs #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pattern_length(len),
		.cell_ctl      (cell_ctl)
	);

	// Window chain: cell 0 takes the new word, each cell hands its byte on.
	// Stale bytes from an earlier stream never reach the compare, because a
	// match also needs len bytes of the current stream (position check).
	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
		logic [7:0] din;
		if (i == 0) begin : g_head
			assign din = s_tdata;
		end else begin : g_link
			assign din = win[i-1];
		end
		mbps_cell u_cell (
			.clk  (clk),
			.shift(in_acc),
			.din  (din),
			.ctl  (cell_ctl[i]),
			.q    (win[i]),
			.ok   (cell_ok[i])
		);
	end

	// s1 moves on when the output register is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	// position of the incoming word; saturates, restarts after last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				if (s_tlast) begin
					pos_q <= '0;
				end else if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1 <= s_tlast;
			pos_s1  <= pos_q;
		end
	end

	// s1 compare: all cells in parallel, the window now holds the s1 byte
	assign len_m1      = OFFSET_BITS'(len) - 1'b1;
	assign len_ok      = (len != '0) && ({1'b0, len} <= LEN_MAX);
	assign hit         = !found_q && len_ok && (pos_s1 >= len_m1) && (&cell_ok);
	assign emit        = hit || (last_s1 && !found_q);
	assign offset_full = pos_s1 - len_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_found_q  <= hit;
			out_offset_q <= hit ? 32'(offset_full) : 32'd0;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_found_q;
	assign m_tdata    = out_offset_q;

	// checks
	`MBPS_ASSERT_IMP(a_miss_zero_offset, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
	`MBPS_ASSERT_IMP(a_one_result_per_stream, adv && found_q, !emit)
	`MBPS_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && out_valid_q && !m_tready)
	`MBPS_ASSERT_NXT(a_drain_empty, m_tvalid && m_tready && !adv, !m_tvalid)

endmodule

/* tb/sv/tb_masked_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_search
// Self-checking bench for the masked byte pattern search. A queue-fed driver
// streams bytes, a scan predictor tracks window, position and found flag, and
// a monitor compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search;
	import mbps_pkg::*;

	// register slots that the block must ignore
	localparam logic [2:0] REG_SPARE6 = 3'd6;
	localparam logic [2:0] REG_SPARE7 = 3'd7;

	localparam int WIN_BYTES   = 32;
	localparam int HOLD_PHASE  = 6;  // receiver back-pressure phase
	localparam int QUIET_PHASE = 3;  // no idling on either side
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_word_t;

	typedef struct {
		logic        found;
		logic [31:0] offset;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [31:0]         m_tdata;
	logic [0:0]          m_tuser;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	masked_byte_pattern_search i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] data_byte
		.s_tlast  (s_tlast),   // last_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] match_offset
		.m_tuser  (m_tuser),   // [0] found
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// ---- bench-side copy of the configuration ----
	logic [63:0] pat_word [4] = '{default: '0};
	logic [31:0] care_bits = '0;
	logic [5:0]  pat_len = '0;

	// ---- scan state mirrored by the predictor ----
	logic [7:0]  win [WIN_BYTES] = '{default: '0};
	logic [31:0] scan_pos = '0;
	logic        hit_seen = 1'b0;

	stream_word_t bytes_to_send [$];
	scan_result_t pending_hits [$];
	stream_word_t next_word;
	scan_result_t oldest_hit;

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatches = 0;

	// flow-control knobs, written by the sequencer only
	logic quiet = 1'b0;
	logic want_hold = 1'b0;
	// owned by the monitor
	logic hold_done = 1'b0;
	int   stall_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	// Pattern byte j lines up with the window entry len-1-j, so byte 0 of the
	// pattern is the oldest byte of the candidate match.
	function automatic logic window_hit(input int unsigned n);
		int unsigned j;
		for (j = 0; j < n; j++) begin
			if (j < 32 && care_bits[j]) begin
				if (win[n-1-j] != pat_word[j/8][8*(j%8) +: 8])
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic clear_scan();
		int i;
		for (i = 0; i < WIN_BYTES; i++)
			win[i] = '0;
		scan_pos = '0;
		hit_seen = 1'b0;
	endtask

	// One accepted byte: shift, compare, queue at most one result word.
	task automatic advance_scan(input logic [7:0] b, input logic last);
		scan_result_t r;
		logic [31:0]  p;
		logic [31:0]  span;
		int           i;
		p = scan_pos;
		span = {26'd0, pat_len} - 32'd1;
		for (i = WIN_BYTES - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = b;
		if (!hit_seen && pat_len != 0 && pat_len <= WIN_BYTES && p >= span &&
				window_hit(32'(pat_len))) begin
			hit_seen = 1'b1;
			r.found = 1'b1;
			r.offset = p - span;
			pending_hits = {pending_hits, r};
		end else if (last && !hit_seen) begin
			// stream ended with no match
			r.found = 1'b0;
			r.offset = '0;
			pending_hits = {pending_hits, r};
		end
		if (p != '1)
			p++;   // counter saturates
		scan_pos = p;
		if (last)
			clear_scan();
	endtask

	// Setup then access cycle; the write lands at the access edge.
	task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[idx] = val;
			REG_CARE: care_bits = val[31:0];
			REG_LEN:  pat_len = val[5:0];
			default: ;   // unmapped slot, ignored
		endcase
	endtask

	task automatic load_setup(input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3,
			input logic [31:0] care, input logic [5:0] len);
		logic [63:0] len_val;
		len_val = {$urandom, $urandom};
		len_val[5:0] = len;   // upper bits are junk the block must drop
		apb_write(REG_PAT0, w0);
		apb_write(REG_PAT1, w1);
		apb_write(REG_PAT2, w2);
		apb_write(REG_PAT3, w3);
		apb_write(REG_CARE, {$urandom, care});
		apb_write(REG_LEN, len_val);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		stream_word_t w;
		w.data = b;
		w.last = last;
		bytes_to_send = {bytes_to_send, w};
		items_queued++;
	endtask

	// mode 0: noise; 1: pattern planted with random wildcards; 2: planted, then
	// one byte spoiled if that byte is cared
	task automatic add_stream(input int n_bytes, input int mode);
		logic [7:0] body [64];
		int         start;
		int         j;
		int         len_i;
		len_i = int'(pat_len);
		for (j = 0; j < n_bytes; j++)
			body[j] = 8'($urandom);
		if (mode != 0 && len_i >= 1 && len_i <= WIN_BYTES && n_bytes >= len_i) begin
			start = $urandom_range(n_bytes - len_i, 0);
			for (j = 0; j < len_i; j++) begin
				if (care_bits[j])
					body[start+j] = pat_word[j/8][8*(j%8) +: 8];
			end
			if (mode == 2) begin
				j = $urandom_range(len_i - 1, 0);
				if (care_bits[j])
					body[start+j] = ~pat_word[j/8][8*(j%8) +: 8];
			end
		end
		for (j = 0; j < n_bytes; j++)
			push_byte(body[j], j == n_bytes - 1);
	endtask

	// Wait until every byte is in and every result is out, then let any
	// result-less byte clear the two-stage pipe.
	task automatic drain();
		while (!(items_taken == items_queued && pending_hits.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---- driver: predicts on accept, then offers the next word ----
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_scan(s_tdata, s_tlast);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (bytes_to_send.size() != 0 && (quiet || $urandom_range(99) >= 29)) begin
					next_word = bytes_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_word.data;
					s_tlast <= next_word.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor: checks result words, owns m_tready and the long hold ----
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_hits.size() == 0) begin
					$error("unexpected result word: found=%0d match_offset=%0d",
						m_tuser[0], m_tdata);
					mismatches++;
				end else begin
					oldest_hit = pending_hits.pop_front();
					if (m_tuser[0] !== oldest_hit.found) begin
						$error("found: expected %0d, actual %0d", oldest_hit.found, m_tuser[0]);
						mismatches++;
					end
					if (m_tdata !== oldest_hit.offset) begin
						$error("match_offset: expected %0d, actual %0d",
							oldest_hit.offset, m_tdata);
						mismatches++;
					end
				end
			end
			if (want_hold && !hold_done) begin
				stall_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 29);
			end
		end
	end

	// ---- sequencer ----
	initial begin
		int          ph;
		int          k;
		int          n;
		int          r;
		int          mode;
		int          n_bytes;
		logic [63:0] words [4];
		logic [31:0] care_v;
		logic [5:0]  len_v;

		clear_scan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: zero length never matches
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		drain();

		// four cared bytes 00 FF A5 5A, other words all ones
		load_setup(64'hFFFF_FFFF_5AA5_FF00, '1, '1, '1, 32'h0000_000F, 6'd4);
		// match at offset 1; the second copy and the end stay silent
		push_byte(8'h11, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h33, 1'b1);
		// too short for the pattern
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		// match completes on the last byte
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b1);
		drain();

		// second byte wildcard
		load_setup(64'h0000_0000_0000_0000, '0, '0, '0, 32'h0000_0001, 6'd2);
		push_byte(8'h00, 1'b0);
		push_byte(8'hC3, 1'b1);
		drain();

		// length over the window, plus writes to unmapped slots
		apb_write(REG_LEN, 64'hFFFF_FFFF_FFFF_FFE1);
		apb_write(REG_SPARE6, 64'h0000_0000_0000_0001);
		apb_write(REG_SPARE7, '1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		drain();

		// random phases
		for (ph = 0; ph < 10; ph++) begin
			for (k = 0; k < 4; k++)
				words[k] = {$urandom, $urandom};
			care_v = $urandom;
			len_v = 6'($urandom_range(8, 1));
			case (ph)
				0: begin
					len_v = 6'd32;
					care_v = '1;
				end
				1: begin
					len_v = 6'd32;
					care_v = '0;
					for (k = 0; k < 4; k++)
						words[k] = '1;
				end
				2: begin
					care_v = '1;
					for (k = 0; k < 4; k++)
						words[k] = '0;
				end
				4: len_v = 6'd63;
				HOLD_PHASE: begin
					// every short stream matches on its first byte
					len_v = 6'd1;
					care_v = '0;
				end
				default: begin
					r = $urandom_range(9, 0);
					if (r == 0)
						len_v = '0;
					else if (r == 1)
						care_v = '1;
					else if (r == 2)
						len_v = 6'($urandom_range(31, 9));
				end
			endcase
			load_setup(words[0], words[1], words[2], words[3], care_v, len_v);
			if (ph % 2 == 1)
				apb_write(ph % 4 == 1 ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});

			quiet = (ph == QUIET_PHASE);
			n = 0;
			while (n < (ph == QUIET_PHASE ? 80 : 35)) begin
				r = $urandom_range(9, 0);
				mode = r < 6 ? 1 : (r < 8 ? 2 : 0);
				if (ph == HOLD_PHASE)
					n_bytes = $urandom_range(4, 1);
				else if (mode != 0 && pat_len >= 1 && pat_len <= WIN_BYTES)
					n_bytes = int'(pat_len) + $urandom_range(10, 0);
				else
					n_bytes = $urandom_range(12, 1);
				add_stream(n_bytes, mode);
				n += n_bytes;
			end
			if (ph == HOLD_PHASE)
				want_hold = 1'b1;
			drain();
			quiet = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
